FILE: rtl/ramp_soak_setpoint_generator_macros.svh
// Assertion macros for the ramp/soak setpoint generator.
// Used by modules that check their own state; expects clk and rst_n in scope.
`ifndef RAMP_SOAK_SETPOINT_GENERATOR_MACROS_SVH
`define RAMP_SOAK_SETPOINT_GENERATOR_MACROS_SVH

// consequent holds in the same cycle
`define RSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the following cycle
`define RSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rsg_pkg.sv
// Package for the ramp/soak setpoint generator: widths, codes, reset values,
// structs and the ramp and step helper functions. No dependencies.
`timescale 1ns / 1ps

package rsg_pkg;

  localparam int TEMP_W   = 19;
  localparam int CNT_W    = 14;
  localparam int RATE_W   = 20;
  localparam int STEP_W   = 15;
  localparam int DELTA_W  = TEMP_W + 1;
  localparam int SUM_W    = TEMP_W + 2;
  localparam int RECIP_W  = 21;
  localparam int PROD_W   = RATE_W + RECIP_W;
  localparam int STEP_SHIFT = PROD_W - STEP_W;

  // floor(rate / 60) as (rate * ceil(2^26 / 60)) >> 26, exact for 20-bit rates
  localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(1118482);
  localparam logic [STEP_W-1:0]  MIN_STEP   = STEP_W'(100);

  localparam int TEMP_MIN_MDEG = -20000;
  localparam int TEMP_MAX_MDEG = 100000;
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(TEMP_MIN_MDEG);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(TEMP_MAX_MDEG);

  localparam logic signed [TEMP_W-1:0] START_TEMP_RST  = TEMP_W'(25000);
  localparam logic [CNT_W-1:0]         HOLD_RST        = CNT_W'(60);
  localparam logic [RATE_W-1:0]        PROG_RATE_RST   = RATE_W'(2000);
  localparam logic signed [TEMP_W-1:0] NEXT_TEMP_RST   = TEMP_W'(35000);
  localparam logic [CNT_W-1:0]         WAIT_RST        = CNT_W'(30);
  localparam logic [CNT_W-1:0]         REPEAT_RST      = CNT_W'(3);
  localparam logic [RATE_W-1:0]        JUMP_RATE_RST   = RATE_W'(60000);
  localparam logic signed [TEMP_W-1:0] JUMP_TARGET_RST = TEMP_W'(25000);
  localparam logic signed [TEMP_W-1:0] SETPOINT_RST    = TEMP_W'(25000);

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_START_JUMP = 3'd1,
    ACT_START_PROG = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_FAULT      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_JUMP = 2'd1,
    MODE_PROG = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TO_START = 3'd1,
    PH_HOLD     = 3'd2,
    PH_RAMP     = 3'd3,
    PH_WAIT     = 3'd4,
    PH_FINISHED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CFG_START_TEMP  = 3'd0,
    CFG_HOLD        = 3'd1,
    CFG_PROG_RATE   = 3'd2,
    CFG_NEXT_TEMP   = 3'd3,
    CFG_WAIT        = 3'd4,
    CFG_REPEAT      = 3'd5,
    CFG_JUMP_RATE   = 3'd6,
    CFG_JUMP_TARGET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] start_mdeg;
    logic [CNT_W-1:0]         hold;
    logic [STEP_W-1:0]        prog_step;
    logic                     prog_zero;
    logic signed [TEMP_W-1:0] next_mdeg;
    logic [CNT_W-1:0]         wait_cnt;
    logic [CNT_W-1:0]         repeat_cnt;
    logic [STEP_W-1:0]        jump_step;
    logic                     jump_zero;
    logic signed [TEMP_W-1:0] jump_target;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint_mdeg;
    mode_t                    run_state;
    phase_t                   phase;
    logic                     start_refused;
  } res_t;

  function automatic logic [STEP_W-1:0] rate_step(input logic [RATE_W-1:0] rate);
    logic [PROD_W-1:0] prod;
    logic [STEP_W-1:0] q;
    prod = PROD_W'(rate) * PROD_W'(STEP_RECIP);
    q = prod[STEP_SHIFT +: STEP_W];
    if (q < MIN_STEP) begin
      q = MIN_STEP;
    end
    return q;
  endfunction

  function automatic logic signed [TEMP_W-1:0] ramp(
    input logic signed [TEMP_W-1:0] cur,
    input logic signed [TEMP_W-1:0] tgt,
    input logic                     zero,
    input logic [STEP_W-1:0]        step
  );
    logic signed [DELTA_W-1:0] diff;
    logic [DELTA_W-1:0]        mag;
    logic signed [DELTA_W-1:0] stp;
    logic signed [DELTA_W-1:0] moved;
    logic signed [TEMP_W-1:0]  res;
    diff = {tgt[TEMP_W-1], tgt} - {cur[TEMP_W-1], cur};
    mag = diff[DELTA_W-1] ? unsigned'(-diff) : unsigned'(diff);
    stp = signed'({{(DELTA_W-STEP_W){1'b0}}, step});
    if (diff[DELTA_W-1]) begin
      moved = {cur[TEMP_W-1], cur} - stp;
    end else begin
      moved = {cur[TEMP_W-1], cur} + stp;
    end
    if (zero || (mag <= unsigned'(stp))) begin
      res = tgt;
    end else begin
      res = moved[TEMP_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/rsg_cfg_regs.sv
// Configuration register bank for the setpoint generator.
// Stores the eight registers, each rate kept as its per-tick step and a zero flag; uses rsg_pkg.
`timescale 1ns / 1ps

module rsg_cfg_regs import rsg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [RATE_W-1:0]   cfg_wdata,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  cfg_idx_t idx;

  assign idx = cfg_idx_t'(cfg_index);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mdeg  <= START_TEMP_RST;
      cfg_r.hold        <= HOLD_RST;
      cfg_r.prog_step   <= rate_step(PROG_RATE_RST);
      cfg_r.prog_zero   <= 1'b0;
      cfg_r.next_mdeg   <= NEXT_TEMP_RST;
      cfg_r.wait_cnt    <= WAIT_RST;
      cfg_r.repeat_cnt  <= REPEAT_RST;
      cfg_r.jump_step   <= rate_step(JUMP_RATE_RST);
      cfg_r.jump_zero   <= 1'b0;
      cfg_r.jump_target <= JUMP_TARGET_RST;
    end else if (cfg_valid) begin
      case (idx)
        CFG_START_TEMP:  cfg_r.start_mdeg  <= signed'(cfg_wdata[TEMP_W-1:0]);
        CFG_HOLD:        cfg_r.hold        <= cfg_wdata[CNT_W-1:0];
        CFG_PROG_RATE: begin
          cfg_r.prog_step <= rate_step(cfg_wdata);
          cfg_r.prog_zero <= (cfg_wdata == '0);
        end
        CFG_NEXT_TEMP:   cfg_r.next_mdeg   <= signed'(cfg_wdata[TEMP_W-1:0]);
        CFG_WAIT:        cfg_r.wait_cnt    <= cfg_wdata[CNT_W-1:0];
        CFG_REPEAT:      cfg_r.repeat_cnt  <= cfg_wdata[CNT_W-1:0];
        CFG_JUMP_RATE: begin
          cfg_r.jump_step <= rate_step(cfg_wdata);
          cfg_r.jump_zero <= (cfg_wdata == '0);
        end
        CFG_JUMP_TARGET: cfg_r.jump_target <= signed'(cfg_wdata[TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/rsg_core.sv
// Setpoint update logic: run mode, program sequencer, counters and setpoint.
// Uses rsg_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "ramp_soak_setpoint_generator_macros.svh"

module rsg_core import rsg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [2:0]               action,
  input  logic signed [TEMP_W-1:0] measured_temp,
  input  logic                     fault_present,
  input  cfg_t                     cfg,
  output res_t                     res_nxt
);

  mode_t                     mode_r, mode_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [CNT_W-1:0]          sc_r, sc_nxt;
  logic [CNT_W-1:0]          sd_r, sd_nxt;
  logic signed [TEMP_W-1:0]  st_r, st_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [TEMP_W-1:0]  sp_r, sp_nxt;
  logic                      fault_r, fault_nxt;
  logic                      refused;

  action_t                   act;
  logic signed [TEMP_W-1:0]  rtgt;
  logic                      rzero;
  logic [STEP_W-1:0]         rstep;
  logic signed [TEMP_W-1:0]  rsp;
  logic signed [SUM_W-1:0]   st_sum;
  logic signed [TEMP_W-1:0]  st_clamp;

  assign act = action_t'(action);

  always_comb begin
    if (mode_r == MODE_JUMP) begin
      rtgt  = cfg.jump_target;
      rzero = cfg.jump_zero;
      rstep = cfg.jump_step;
    end else if (phase_r == PH_TO_START) begin
      rtgt  = cfg.start_mdeg;
      rzero = cfg.jump_zero;
      rstep = cfg.jump_step;
    end else begin
      rtgt  = st_r;
      rzero = cfg.prog_zero;
      rstep = cfg.prog_step;
    end
  end

  assign rsp = ramp(sp_r, rtgt, rzero, rstep);

  assign st_sum = {{2{st_r[TEMP_W-1]}}, st_r} + {delta_r[DELTA_W-1], delta_r};

  always_comb begin
    if (st_sum < SUM_MIN) begin
      st_clamp = SUM_MIN[TEMP_W-1:0];
    end else if (st_sum > SUM_MAX) begin
      st_clamp = SUM_MAX[TEMP_W-1:0];
    end else begin
      st_clamp = st_sum[TEMP_W-1:0];
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    sc_nxt    = sc_r;
    sd_nxt    = sd_r;
    st_nxt    = st_r;
    delta_nxt = delta_r;
    sp_nxt    = sp_r;
    fault_nxt = fault_r;
    refused   = 1'b0;
    case (act)
      ACT_TICK: begin
        if (mode_r == MODE_JUMP) begin
          sp_nxt = rsp;
        end else if (mode_r == MODE_PROG) begin
          case (phase_r)
            PH_TO_START: begin
              sp_nxt = rsp;
              if (rsp == cfg.start_mdeg) begin
                phase_nxt = PH_HOLD;
                sc_nxt    = '0;
              end
            end
            PH_HOLD: begin
              sp_nxt = cfg.start_mdeg;
              if (sc_r >= cfg.hold) begin
                phase_nxt = PH_RAMP;
                sc_nxt    = '0;
                st_nxt    = cfg.next_mdeg;
              end else begin
                sc_nxt = sc_r + 1'b1;
              end
            end
            PH_RAMP: begin
              sp_nxt = rsp;
              if (rsp == st_r) begin
                phase_nxt = PH_WAIT;
                sc_nxt    = '0;
              end
            end
            PH_WAIT: begin
              sp_nxt = st_r;
              if (sc_r >= cfg.wait_cnt) begin
                sc_nxt = '0;
                if (sd_r >= cfg.repeat_cnt) begin
                  phase_nxt = PH_FINISHED;
                end else begin
                  sd_nxt    = sd_r + 1'b1;
                  st_nxt    = st_clamp;
                  phase_nxt = PH_RAMP;
                end
              end else begin
                sc_nxt = sc_r + 1'b1;
              end
            end
            PH_FINISHED: begin
              sp_nxt = st_r;
            end
            default: begin
              phase_nxt = PH_TO_START;
            end
          endcase
        end
      end
      ACT_START_JUMP: begin
        if (fault_r) begin
          refused = 1'b1;
        end else begin
          mode_nxt  = MODE_JUMP;
          phase_nxt = PH_IDLE;
          sc_nxt    = '0;
          sd_nxt    = '0;
          sp_nxt    = measured_temp;
        end
      end
      ACT_START_PROG: begin
        if (fault_r) begin
          refused = 1'b1;
        end else begin
          mode_nxt  = MODE_PROG;
          phase_nxt = PH_TO_START;
          sc_nxt    = '0;
          sd_nxt    = '0;
          delta_nxt = {cfg.next_mdeg[TEMP_W-1], cfg.next_mdeg}
                    - {cfg.start_mdeg[TEMP_W-1], cfg.start_mdeg};
          st_nxt    = cfg.start_mdeg;
          sp_nxt    = measured_temp;
        end
      end
      ACT_STOP: begin
        mode_nxt  = MODE_STOP;
        phase_nxt = PH_IDLE;
        sc_nxt    = '0;
        sd_nxt    = '0;
      end
      ACT_FAULT: begin
        fault_nxt = fault_present;
        if (fault_present) begin
          mode_nxt  = MODE_STOP;
          phase_nxt = PH_IDLE;
          sc_nxt    = '0;
          sd_nxt    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STOP;
      phase_r <= PH_IDLE;
      sc_r    <= '0;
      sd_r    <= '0;
      st_r    <= '0;
      delta_r <= '0;
      sp_r    <= SETPOINT_RST;
      fault_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      sc_r    <= sc_nxt;
      sd_r    <= sd_nxt;
      st_r    <= st_nxt;
      delta_r <= delta_nxt;
      sp_r    <= sp_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign res_nxt.setpoint_mdeg = sp_nxt;
  assign res_nxt.run_state     = mode_nxt;
  assign res_nxt.phase         = phase_nxt;
  assign res_nxt.start_refused = refused;

  `RSG_ASSERT_SAME(a_stop_clean, mode_r == MODE_STOP,
    (phase_r == PH_IDLE) && (sc_r == '0) && (sd_r == '0), "stopped with live sequencer")
  `RSG_ASSERT_SAME(a_jump_idle, mode_r == MODE_JUMP, phase_r == PH_IDLE,
    "jump mode with program phase")
  `RSG_ASSERT_SAME(a_fault_stop, fault_r, mode_r == MODE_STOP, "running with fault latched")
  `RSG_ASSERT_NEXT(a_refuse_hold,
    fire && fault_r && ((act == ACT_START_JUMP) || (act == ACT_START_PROG)),
    (mode_r == $past(mode_r)) && (sp_r == $past(sp_r)), "refused start changed state")

endmodule

FILE: rtl/ramp_soak_setpoint_generator.sv
// Top level of the ramp/soak setpoint generator for one cell.
// Instantiates rsg_cfg_regs and rsg_core; holds input and result registers.
//
//   channel  direction  handshake           beat contents
//   in_      input      in_valid/in_stall   action, measured_temp, fault_present
//   out_     output     out_valid/out_stall setpoint, run state, phase, refused flag
//   cfg_     input      cfg_valid/cfg_ready register index, write data
//
// One beat a cycle sustained while out_stall is low; a result beat is offered
// when the result register loads it, and can be taken at the following edge.
// Input register feeds the update logic, which feeds the result register.
// The input side stalls only when both registers are full and out_stall is high.
// Synchronous active-low reset restores register defaults and stops the cell.
// Config writes are always ready and apply to beats processed after the write.
`timescale 1ns / 1ps

module ramp_soak_setpoint_generator import rsg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_action,
  input  logic signed [TEMP_W-1:0] in_measured_temp,
  input  logic                     in_fault_present,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_command_temp,
  output logic [1:0]               out_run_state,
  output logic [2:0]               out_phase,
  output logic                     out_start_refused,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [RATE_W-1:0]        cfg_wdata
);

  logic                     in_v_r;
  logic [2:0]               act_r;
  logic signed [TEMP_W-1:0] meas_r;
  logic                     fault_in_r;
  logic                     out_v_r;
  res_t                     res_r;
  res_t                     res_nxt;
  cfg_t                     cfg;
  logic                     accept;
  logic                     fire;

  assign cfg_ready = 1'b1;
  assign fire      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !fire;
  assign accept    = in_valid && !in_stall;

  rsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsg_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .action        (act_r),
    .measured_temp (meas_r),
    .fault_present (fault_in_r),
    .cfg           (cfg),
    .res_nxt       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= accept || (in_v_r && !fire);
      out_v_r <= fire || (out_v_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= in_action;
      meas_r     <= in_measured_temp;
      fault_in_r <= in_fault_present;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_command_temp  = res_r.setpoint_mdeg;
  assign out_run_state     = res_r.run_state;
  assign out_phase         = res_r.phase;
  assign out_start_refused = res_r.start_refused;

endmodule

FILE: verif/ramp_soak_setpoint_generator_tb.sv
// Testbench for ramp_soak_setpoint_generator: directed and random command beats,
// a per-beat setpoint predictor and a result checker with random idling and stalls.
// Depends on rsg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module ramp_soak_setpoint_generator_tb import rsg_pkg::*; ();

  localparam int TICKS_PER_MIN   = 60;
  localparam int MIN_STEP_MDEG   = 100;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLDOFF_CYCLES  = 150;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 6;
  localparam int PRESSURE_PHASE  = 4;
  localparam int NUM_REGS        = 8;
  localparam int PICK_RANDOM     = 0;
  localparam int PICK_LOW        = 1;
  localparam int PICK_HIGH       = 2;

  typedef struct {
    logic [2:0]               action;
    logic signed [TEMP_W-1:0] measured;
    logic                     fault;
  } cell_cmd_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [1:0]               mode;
    logic [2:0]               phase;
    logic                     refused;
  } setpoint_beat_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_action = '0;
  logic signed [TEMP_W-1:0] in_measured_temp = '0;
  logic                     in_fault_present = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_command_temp;
  logic [1:0]               out_run_state;
  logic [2:0]               out_phase;
  logic                     out_start_refused;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = '0;
  logic [RATE_W-1:0]        cfg_wdata = '0;

  cell_cmd_t      cmd_queue[$];
  setpoint_beat_t setpoint_fifo[$];
  int             total_pushed = 0;
  int             err_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             holdoff_asked = 0;
  int             holdoff_served = 0;
  int             holdoff_left = 0;
  logic           beat_taken = 1'b0;

  // predictor copy of the register file and cell state
  int               cfg_start, cfg_next, cfg_jump_tgt;
  logic [CNT_W-1:0] cfg_hold, cfg_wait, cfg_repeat;
  int unsigned      cfg_prog_rate, cfg_jump_rate;
  logic [1:0]       model_mode;
  logic [2:0]       cell_phase;
  logic [CNT_W-1:0] sec_cnt, steps_done;
  int               step_tgt, step_delta, cell_sp;
  logic             fault_held;

  ramp_soak_setpoint_generator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_measured_temp  (in_measured_temp),
    .in_fault_present  (in_fault_present),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command_temp  (out_command_temp),
    .out_run_state     (out_run_state),
    .out_phase         (out_phase),
    .out_start_refused (out_start_refused),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void reset_cell_model();
    cfg_start     = START_TEMP_RST;
    cfg_hold      = HOLD_RST;
    cfg_prog_rate = PROG_RATE_RST;
    cfg_next      = NEXT_TEMP_RST;
    cfg_wait      = WAIT_RST;
    cfg_repeat    = REPEAT_RST;
    cfg_jump_rate = JUMP_RATE_RST;
    cfg_jump_tgt  = JUMP_TARGET_RST;
    model_mode    = MODE_STOP;
    cell_phase    = PH_IDLE;
    sec_cnt       = '0;
    steps_done    = '0;
    step_tgt      = 0;
    step_delta    = 0;
    cell_sp       = SETPOINT_RST;
    fault_held    = 1'b0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [RATE_W-1:0] d);
    case (idx)
      CFG_START_TEMP:  cfg_start = $signed(d[TEMP_W-1:0]);
      CFG_HOLD:        cfg_hold = d[CNT_W-1:0];
      CFG_PROG_RATE:   cfg_prog_rate = d;
      CFG_NEXT_TEMP:   cfg_next = $signed(d[TEMP_W-1:0]);
      CFG_WAIT:        cfg_wait = d[CNT_W-1:0];
      CFG_REPEAT:      cfg_repeat = d[CNT_W-1:0];
      CFG_JUMP_RATE:   cfg_jump_rate = d;
      CFG_JUMP_TARGET: cfg_jump_tgt = $signed(d[TEMP_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic int ramp_toward(int cur, int tgt, int unsigned rate);
    int stp;
    int diff;
    if (rate == 0) return tgt;
    diff = tgt - cur;
    stp = rate / TICKS_PER_MIN;
    if (stp < MIN_STEP_MDEG) stp = MIN_STEP_MDEG;
    if (diff > 0) return (diff <= stp) ? tgt : cur + stp;
    if (diff < 0) return (-diff <= stp) ? tgt : cur - stp;
    return tgt;
  endfunction

  function automatic void halt_cell();
    model_mode = MODE_STOP;
    cell_phase = PH_IDLE;
    sec_cnt    = '0;
    steps_done = '0;
  endfunction

  function automatic void tick_program();
    case (cell_phase)
      PH_TO_START: begin
        cell_sp = ramp_toward(cell_sp, cfg_start, cfg_jump_rate);
        if (cell_sp == cfg_start) begin
          cell_phase = PH_HOLD;
          sec_cnt = '0;
        end
      end
      PH_HOLD: begin
        cell_sp = cfg_start;
        if (sec_cnt >= cfg_hold) begin
          cell_phase = PH_RAMP;
          sec_cnt = '0;
          step_tgt = cfg_next;
        end else begin
          sec_cnt = sec_cnt + 1'b1;
        end
      end
      PH_RAMP: begin
        cell_sp = ramp_toward(cell_sp, step_tgt, cfg_prog_rate);
        if (cell_sp == step_tgt) begin
          cell_phase = PH_WAIT;
          sec_cnt = '0;
        end
      end
      PH_WAIT: begin
        cell_sp = step_tgt;
        if (sec_cnt >= cfg_wait) begin
          sec_cnt = '0;
          if (steps_done >= cfg_repeat) begin
            cell_phase = PH_FINISHED;
          end else begin
            steps_done = steps_done + 1'b1;
            step_tgt = step_tgt + step_delta;
            if (step_tgt < TEMP_MIN_MDEG) step_tgt = TEMP_MIN_MDEG;
            if (step_tgt > TEMP_MAX_MDEG) step_tgt = TEMP_MAX_MDEG;
            cell_phase = PH_RAMP;
          end
        end else begin
          sec_cnt = sec_cnt + 1'b1;
        end
      end
      PH_FINISHED: cell_sp = step_tgt;
      default: cell_phase = PH_TO_START;
    endcase
  endfunction

  function automatic setpoint_beat_t step_cell(cell_cmd_t c);
    setpoint_beat_t beat;
    logic           refused;
    refused = 1'b0;
    case (c.action)
      ACT_TICK: begin
        if (model_mode == MODE_JUMP) cell_sp = ramp_toward(cell_sp, cfg_jump_tgt, cfg_jump_rate);
        else if (model_mode == MODE_PROG) tick_program();
      end
      ACT_START_JUMP: begin
        if (fault_held) begin
          refused = 1'b1;
        end else begin
          model_mode = MODE_JUMP;
          cell_phase = PH_IDLE;
          sec_cnt    = '0;
          steps_done = '0;
          cell_sp    = c.measured;
        end
      end
      ACT_START_PROG: begin
        if (fault_held) begin
          refused = 1'b1;
        end else begin
          model_mode = MODE_PROG;
          cell_phase = PH_TO_START;
          sec_cnt    = '0;
          steps_done = '0;
          step_delta = cfg_next - cfg_start;
          step_tgt   = cfg_start;
          cell_sp    = c.measured;
        end
      end
      ACT_STOP: halt_cell();
      ACT_FAULT: begin
        fault_held = c.fault;
        if (c.fault) halt_cell();
      end
      default: ;
    endcase
    beat.temp    = TEMP_W'(cell_sp);
    beat.mode    = model_mode;
    beat.phase   = cell_phase;
    beat.refused = refused;
    return beat;
  endfunction

  function automatic void push_cmd(logic [2:0] act, logic signed [TEMP_W-1:0] meas, logic flt);
    cell_cmd_t c;
    c.action   = act;
    c.measured = meas;
    c.fault    = flt;
    cmd_queue.push_back(c);
    total_pushed++;
  endfunction

  function automatic logic signed [TEMP_W-1:0] any_temp();
    if ($urandom_range(0, 9) < 3) return TEMP_W'($urandom);
    return TEMP_W'(int'($urandom_range(0, 140000)) - 30000);
  endfunction

  function automatic void push_noise();
    push_cmd(3'($urandom), any_temp(), 1'($urandom));
  endfunction

  function automatic void push_ticks(int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) push_noise();
      else push_cmd(ACT_TICK, any_temp(), 1'($urandom));
    end
  endfunction

  function automatic void queue_run();
    int                       sel;
    logic signed [TEMP_W-1:0] origin;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      if ($urandom_range(0, 2) == 0) push_cmd(ACT_FAULT, any_temp(), 1'b0);
      origin = ($urandom_range(0, 1) == 0) ?
               TEMP_W'(cfg_start + int'($urandom_range(0, 20000)) - 10000) : any_temp();
      if (sel < 45) begin
        push_cmd(ACT_START_PROG, origin, 1'($urandom));
        push_ticks($urandom_range(10, 60));
      end else begin
        push_cmd(ACT_START_JUMP, origin, 1'($urandom));
        push_ticks($urandom_range(3, 25));
      end
    end else if (sel < 75) begin
      push_cmd(ACT_FAULT, any_temp(), 1'b1);
      push_cmd($urandom_range(0, 1) ? ACT_START_JUMP : ACT_START_PROG, any_temp(), 1'($urandom));
      push_ticks($urandom_range(0, 3));
      push_cmd(ACT_FAULT, any_temp(), 1'b0);
    end else if (sel < 85) begin
      push_cmd(ACT_STOP, any_temp(), 1'($urandom));
      push_ticks($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 4)) push_noise();
    end
  endfunction

  function automatic logic [RATE_W-1:0] pick_reg(cfg_idx_t idx, int kind);
    logic [RATE_W-1:0] v;
    int                t;
    v = RATE_W'($urandom);
    case (idx)
      CFG_START_TEMP, CFG_NEXT_TEMP, CFG_JUMP_TARGET: begin
        t = (kind == PICK_LOW) ? -262144 : (kind == PICK_HIGH) ? 262143 :
            int'($urandom_range(0, 140000)) - 30000;
        v[TEMP_W-1:0] = TEMP_W'(t);
      end
      CFG_HOLD, CFG_WAIT, CFG_REPEAT: begin
        v[CNT_W-1:0] = (kind == PICK_LOW) ? '0 : (kind == PICK_HIGH) ? '1 :
                       CNT_W'($urandom_range(0, 4));
      end
      default: begin
        if (kind == PICK_LOW) v = '0;
        else if (kind == PICK_HIGH) v = '1;
        else begin
          case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = RATE_W'($urandom_range(1, 6100));
            default: v = RATE_W'($urandom_range(300000, 1048575));
          endcase
        end
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [RATE_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, d);
  endtask

  // accept a command beat and predict its result
  always @(posedge clk) begin
    cell_cmd_t seen;
    beat_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      seen.action   = in_action;
      seen.measured = in_measured_temp;
      seen.fault    = in_fault_present;
      setpoint_fifo.push_back(step_cell(seen));
      void'(cmd_queue.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!in_valid || beat_taken) begin
      if (rst_n && cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid         <= 1'b1;
        in_action        <= cmd_queue[0].action;
        in_measured_temp <= cmd_queue[0].measured;
        in_fault_present <= cmd_queue[0].fault;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holdoff_asked != holdoff_served) begin
      holdoff_served <= holdoff_asked;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_stall      <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    setpoint_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (setpoint_fifo.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = setpoint_fifo.pop_front();
        if (out_command_temp !== want.temp)
          report_mismatch($sformatf("setpoint got %0d want %0d", out_command_temp, want.temp));
        if (out_run_state !== want.mode)
          report_mismatch($sformatf("run_state got %0d want %0d", out_run_state, want.mode));
        if (out_phase !== want.phase)
          report_mismatch($sformatf("phase got %0d want %0d", out_phase, want.phase));
        if (out_start_refused !== want.refused)
          report_mismatch($sformatf("start_refused got %0d want %0d",
                                    out_start_refused, want.refused));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ramp_soak_setpoint_generator_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [RATE_W-1:0] reg_vals[NUM_REGS];
    int                p;
    int                k;
    int                goal;
    reset_cell_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 0) begin
        reg_vals[CFG_START_TEMP]  = RATE_W'(10000);
        reg_vals[CFG_HOLD]        = RATE_W'(1);
        reg_vals[CFG_PROG_RATE]   = '0;
        reg_vals[CFG_NEXT_TEMP]   = RATE_W'(12000);
        reg_vals[CFG_WAIT]        = '0;
        reg_vals[CFG_REPEAT]      = RATE_W'(1);
        reg_vals[CFG_JUMP_RATE]   = '0;
        reg_vals[CFG_JUMP_TARGET] = RATE_W'(TEMP_W'(-20000));
      end else begin
        for (k = 0; k < NUM_REGS; k++)
          reg_vals[k] = pick_reg(cfg_idx_t'(k), (p == 1) ? PICK_LOW :
                                                (p == 2) ? PICK_HIGH : PICK_RANDOM);
      end
      for (k = 0; k < NUM_REGS; k++) write_reg(cfg_idx_t'(k), reg_vals[k]);
      @(negedge clk);
      cfg_valid = 1'b0;

      if (p == 0) begin
        push_cmd(ACT_TICK, '0, 1'b0);
        for (k = int'(ACT_FAULT) + 1; k < 8; k++) push_cmd(3'(k), any_temp(), 1'(k));
        push_cmd(ACT_START_JUMP, TEMP_W'(-262144), 1'b0);
        push_cmd(ACT_TICK, '0, 1'b1);
        push_cmd(ACT_START_JUMP, TEMP_W'(262143), 1'b1);
        push_cmd(ACT_START_JUMP, TEMP_W'(5000), 1'b0);
        push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_STOP, '0, 1'b0);
        push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_START_PROG, '0, 1'b1);
        repeat (8) push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_FAULT, '0, 1'b1);
        push_cmd(ACT_START_JUMP, '0, 1'b0);
        push_cmd(ACT_START_PROG, '0, 1'b0);
        push_cmd(ACT_FAULT, '0, 1'b0);
        push_cmd(ACT_TICK, '0, 1'b0);
        push_cmd(ACT_START_JUMP, TEMP_W'(100), 1'b0);
        push_cmd(ACT_FAULT, '0, 1'b1);
        push_cmd(ACT_FAULT, '0, 1'b0);
      end else begin
        goal = total_pushed + ITEMS_PER_PHASE;
        while (total_pushed < goal) queue_run();
      end
      if (p == PRESSURE_PHASE) holdoff_asked++;

      while (cmd_queue.size() != 0 || setpoint_fifo.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (err_count == 0) begin
      $display("ramp_soak_setpoint_generator_tb: done, clean");
    end else begin
      $display("ramp_soak_setpoint_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
